// ----- rtl/fndt_pkg.sv -----
package fndt_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int SLOT_W       = 6;
  localparam int USED_W       = 7;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_LIST   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_CREATED   = 4'd0,
    ST_EXISTS    = 4'd1,
    ST_DELETED   = 4'd2,
    ST_NOT_FOUND = 4'd3,
    ST_FOUND     = 4'd4,
    ST_ABSENT    = 4'd5,
    ST_FULL      = 4'd6,
    ST_LISTED    = 4'd7,
    ST_EMPTY     = 4'd8
  } status_t;

  typedef struct packed {
    logic [7:0]  high;
    logic [63:0] low;
  } name_t;

endpackage

// ----- rtl/flat_name_directory_table_core.sv -----
// Flat name directory: up to CAPACITY names of at most nine bytes kept in one
// single-port-read synchronous table, handled one request at a time. Create,
// delete and search scan the table through its read port at one entry per
// cycle after a request is taken; a delete that finds its name then moves the
// last entry into the freed slot. List reads each entry and sends it, one
// result per entry with tlast on the final one; a list of an empty table gives
// a single empty result. A stalled output holds the sequencer; a new request
// is taken once the last result of the previous one is loaded into the output
// register. Table contents are undefined after reset; the entry count is
// cleared, so no clearing pass is needed.
module flat_name_directory_table_core #(
  parameter int CAPACITY = fndt_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // op[1:0], name_low[65:2], name_high[73:66]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // status[3:0], slot[9:4], entry_low[73:10],
                                 // entry_high[81:74], used[88:82]
  output logic        m_tlast
);

  localparam int IW = $clog2(CAPACITY);

  fndt_pkg::op_t                 in_op;
  fndt_pkg::name_t               in_name;
  fndt_pkg::status_t             out_status;
  logic [fndt_pkg::SLOT_W-1:0]   out_slot;
  fndt_pkg::name_t               out_entry;
  logic [fndt_pkg::USED_W-1:0]   out_used;
  logic                          rd_en;
  logic [IW-1:0]                 rd_addr;
  fndt_pkg::name_t               rd_data;
  logic                          wr_en;
  logic [IW-1:0]                 wr_addr;
  fndt_pkg::name_t               wr_data;

  assign in_op        = fndt_pkg::op_t'(s_tdata[1:0]);
  assign in_name.low  = s_tdata[65:2];
  assign in_name.high = s_tdata[73:66];

  assign m_tdata = {7'd0, out_used, out_entry.high, out_entry.low, out_slot, out_status};

  fndt_store #(
    .CAPACITY(CAPACITY)
  ) u_store (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  fndt_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .in_op     (in_op),
    .in_name   (in_name),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tlast   (m_tlast),
    .out_status(out_status),
    .out_slot  (out_slot),
    .out_entry (out_entry),
    .out_used  (out_used),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

endmodule

// ----- rtl/fndt_store.sv -----
module fndt_store #(
  parameter int CAPACITY = fndt_pkg::CAPACITY_DEF,
  localparam int IW = $clog2(CAPACITY)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [IW-1:0]     rd_addr,
  output fndt_pkg::name_t   rd_data,
  input  logic              wr_en,
  input  logic [IW-1:0]     wr_addr,
  input  fndt_pkg::name_t   wr_data
);

  fndt_pkg::name_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/fndt_ctrl.sv -----
module fndt_ctrl #(
  parameter int CAPACITY = fndt_pkg::CAPACITY_DEF,
  localparam int IW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  fndt_pkg::op_t                 in_op,
  input  fndt_pkg::name_t               in_name,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic                          m_tlast,
  output fndt_pkg::status_t             out_status,
  output logic [fndt_pkg::SLOT_W-1:0]   out_slot,
  output fndt_pkg::name_t               out_entry,
  output logic [fndt_pkg::USED_W-1:0]   out_used,
  output logic                          rd_en,
  output logic [IW-1:0]                 rd_addr,
  input  fndt_pkg::name_t               rd_data,
  output logic                          wr_en,
  output logic [IW-1:0]                 wr_addr,
  output fndt_pkg::name_t               wr_data
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_ACT  = 7'b0000100,
    S_MVRD = 7'b0001000,
    S_MVWR = 7'b0010000,
    S_LRD  = 7'b0100000,
    S_LOUT = 7'b1000000
  } state_t;

  state_t          state;
  fndt_pkg::op_t   op;
  fndt_pkg::name_t name;
  fndt_pkg::name_t norm;
  logic [CW-1:0]   count;
  logic [CW-1:0]   idx;
  logic            pend;
  logic [IW-1:0]   pend_idx;
  logic            found;
  logic [IW-1:0]   pos;
  logic            out_free;
  logic            hit;
  logic            scan_end;
  logic            list_end;
  logic            is_full;
  logic [CW-1:0]   count_m1;

  // name ends at its first zero byte
  function automatic fndt_pkg::name_t normalize(fndt_pkg::name_t n);
    fndt_pkg::name_t r;
    logic            keep;
    r    = '0;
    keep = 1'b1;
    for (int b = 0; b < 8; b++) begin
      keep = keep && (n.low[8*b +: 8] != 8'd0);
      if (keep) begin
        r.low[8*b +: 8] = n.low[8*b +: 8];
      end
    end
    if (keep) begin
      r.high = n.high;
    end
    return r;
  endfunction

  assign norm     = normalize(in_name);
  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign count_m1 = count - CW'(1);
  assign hit      = pend && (rd_data == name);
  assign scan_end = pend && (CW'(pend_idx) == count_m1);
  assign list_end = (idx == count_m1);
  assign is_full  = (count == CW'(CAPACITY));

  // reads and writes sit in separate states, so no entry is read and written at once
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx[IW-1:0];
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = name;
    unique case (state)
      S_SCAN: begin
        rd_en = !hit && !scan_end;
      end
      S_ACT: begin
        wr_addr = count[IW-1:0];
        wr_en   = (op == fndt_pkg::OP_CREATE) && !found && !is_full && out_free;
      end
      S_MVRD: begin
        rd_en   = 1'b1;
        rd_addr = count_m1[IW-1:0];
      end
      S_MVWR: begin
        wr_en   = out_free;
        wr_data = rd_data;
      end
      S_LRD: begin
        rd_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op    <= in_op;
            name  <= norm;
            idx   <= '0;
            pend  <= 1'b0;
            found <= 1'b0;
            pos   <= count[IW-1:0];
            if (count == '0) begin
              state <= S_ACT;
            end else if (in_op == fndt_pkg::OP_LIST) begin
              state <= S_LRD;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            found <= 1'b1;
            pos   <= pend_idx;
            state <= S_ACT;
          end else if (scan_end) begin
            state <= S_ACT;
          end else begin
            pend     <= 1'b1;
            pend_idx <= idx[IW-1:0];
            idx      <= idx + CW'(1);
          end
        end
        S_ACT: begin
          if ((op == fndt_pkg::OP_DELETE) && found) begin
            state <= S_MVRD;
          end else if (out_free) begin
            m_tvalid  <= 1'b1;
            m_tlast   <= 1'b1;
            out_entry <= '0;
            out_slot  <= '0;
            out_used  <= fndt_pkg::USED_W'(count);
            state     <= S_IDLE;
            unique case (op)
              fndt_pkg::OP_CREATE: begin
                if (found) begin
                  out_status <= fndt_pkg::ST_EXISTS;
                  out_slot   <= fndt_pkg::SLOT_W'(pos);
                end else if (is_full) begin
                  out_status <= fndt_pkg::ST_FULL;
                end else begin
                  out_status <= fndt_pkg::ST_CREATED;
                  out_slot   <= fndt_pkg::SLOT_W'(pos);
                  out_used   <= fndt_pkg::USED_W'(count + CW'(1));
                  count      <= count + CW'(1);
                end
              end
              fndt_pkg::OP_DELETE: begin
                out_status <= fndt_pkg::ST_NOT_FOUND;
              end
              fndt_pkg::OP_SEARCH: begin
                if (found) begin
                  out_status <= fndt_pkg::ST_FOUND;
                  out_slot   <= fndt_pkg::SLOT_W'(pos);
                end else begin
                  out_status <= fndt_pkg::ST_ABSENT;
                end
              end
              fndt_pkg::OP_LIST: begin
                out_status <= fndt_pkg::ST_EMPTY;
              end
              default: begin
              end
            endcase
          end
        end
        S_MVRD: begin
          state <= S_MVWR;
        end
        S_MVWR: begin
          if (out_free) begin
            m_tvalid   <= 1'b1;
            m_tlast    <= 1'b1;
            out_status <= fndt_pkg::ST_DELETED;
            out_slot   <= fndt_pkg::SLOT_W'(pos);
            out_entry  <= '0;
            out_used   <= fndt_pkg::USED_W'(count_m1);
            count      <= count_m1;
            state      <= S_IDLE;
          end
        end
        S_LRD: begin
          state <= S_LOUT;
        end
        S_LOUT: begin
          if (out_free) begin
            m_tvalid   <= 1'b1;
            m_tlast    <= list_end;
            out_status <= fndt_pkg::ST_LISTED;
            out_slot   <= fndt_pkg::SLOT_W'(idx);
            out_entry  <= rd_data;
            out_used   <= fndt_pkg::USED_W'(count);
            idx        <= idx + CW'(1);
            state      <= list_end ? S_IDLE : S_LRD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/fndt_checker.sv -----
module fndt_checker #(
  parameter int CAPACITY = fndt_pkg::CAPACITY_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata,
  input logic        m_tlast
);

  // one request at a time
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while previous one in progress");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[3:0] != 4'(fndt_pkg::ST_LISTED)) |-> m_tlast)
    else $error("non-list result without tlast");

  a_used_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[88:82] <= 7'(CAPACITY)) && (m_tdata[3:0] <= 4'(fndt_pkg::ST_EMPTY)))
    else $error("result fields out of range");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("not idle after reset");

endmodule

bind flat_name_directory_table_core fndt_checker #(
  .CAPACITY(CAPACITY)
) u_fndt_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast)
);
